/* rtl/core/prm_pkg.sv */
`timescale 1ns / 1ps

package prm_pkg;

  // Widths fixed by the register map and the stream payload
  localparam int unsigned PatMaxDef = 16;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned PatW      = 128;
  localparam int unsigned CfgW      = 64;
  localparam int unsigned AddrW     = 5;
  localparam int unsigned LenW      = 5;

  localparam logic [ByteW-1:0] MarkerReset = 8'h2A;
  localparam logic [LenW-1:0]  LenReset    = 5'd1;

  // Register index, taken from paddr[4:3]
  typedef enum logic [1:0] {
    RegPatLo  = 2'd0,
    RegPatHi  = 2'd1,
    RegPatLen = 2'd2,
    RegMarker = 2'd3
  } reg_idx_e;

  typedef enum logic {
    StIdle,
    StScan
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic emit_mark;
    logic emit_head;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
    logic match;
    logic last;
    logic slot_free;
  } dp_sts_t;

endpackage

/* rtl/core/prm_regs.sv */
`timescale 1ns / 1ps

module prm_regs import prm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [CfgW-1:0]  pwdata,
  output logic [CfgW-1:0]  prdata,
  output logic             pready,
  output logic [PatW-1:0]  pattern_o,
  output logic [LenW-1:0]  pattern_length_o,
  output logic [ByteW-1:0] marker_o
);

  logic [CfgW-1:0]  pat_lo_q;
  logic [CfgW-1:0]  pat_hi_q;
  logic [LenW-1:0]  len_q;
  logic [ByteW-1:0] marker_q;
  logic             wr_en;
  reg_idx_e         idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = reg_idx_e'(paddr[4:3]);

  // Write the addressed register on the access beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q <= '0;
      pat_hi_q <= '0;
      len_q    <= LenReset;
      marker_q <= MarkerReset;
    end else if (wr_en) begin
      case (idx)
        RegPatLo:  pat_lo_q <= pwdata;
        RegPatHi:  pat_hi_q <= pwdata;
        RegPatLen: len_q    <= pwdata[LenW-1:0];
        RegMarker: marker_q <= pwdata[ByteW-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (idx)
      RegPatLo:  prdata = pat_lo_q;
      RegPatHi:  prdata = pat_hi_q;
      RegPatLen: prdata = {{(CfgW-LenW){1'b0}}, len_q};
      RegMarker: prdata = {{(CfgW-ByteW){1'b0}}, marker_q};
      default:   prdata = '0;
    endcase
  end

  assign pattern_o        = {pat_hi_q, pat_lo_q};
  assign pattern_length_o = len_q;
  assign marker_o         = marker_q;

endmodule

/* rtl/core/prm_datapath.sv */
`timescale 1ns / 1ps

module prm_datapath import prm_pkg::*; #(
  parameter  int unsigned PatMax = PatMaxDef,
  localparam int unsigned CntW   = $clog2(PatMax + 1),
  localparam int unsigned IdxW   = (PatMax > 1) ? $clog2(PatMax) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dp_cmd_t          cmd_i,
  output dp_sts_t          sts_o,
  input  logic [ByteW-1:0] text_byte_i,
  input  logic             text_last_i,
  input  logic [PatW-1:0]  pattern_i,
  input  logic [LenW-1:0]  pattern_length_i,
  input  logic [ByteW-1:0] marker_i,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output logic [ByteW-1:0] out_byte_o,
  output logic             out_is_marker_o,
  output logic             out_last_o
);

  logic [ByteW-1:0] buf_q [PatMax];
  logic [ByteW-1:0] buf_d [PatMax];
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             last_q, last_d;
  logic             out_valid_q, out_valid_d;
  logic [ByteW-1:0] out_byte_q, out_byte_d;
  logic             out_mark_q, out_mark_d;
  logic             out_last_q, out_last_d;

  logic [LenW-1:0]  len_clip;
  logic [CntW-1:0]  len;
  logic [CntW-1:0]  cmp;
  logic [CntW-1:0]  sh;
  logic             match;
  logic             full;
  logic             emit;
  logic             slot_free;

  // Clamp the configured length to 1..PatMax
  always_comb begin
    len_clip = pattern_length_i;
    if (len_clip == '0) begin
      len_clip = LenW'(1);
    end else if (len_clip > LenW'(PatMax)) begin
      len_clip = LenW'(PatMax);
    end
  end
  assign len = CntW'(len_clip);
  assign cmp = (cnt_q < len) ? cnt_q : len;

  // Compare the held prefix with the pattern, all positions at once
  always_comb begin
    match = 1'b1;
    for (int i = 0; i < PatMax; i++) begin
      if (CntW'(i) < cmp && buf_q[i] != pattern_i[ByteW*i +: ByteW]) begin
        match = 1'b0;
      end
    end
  end
  assign full = match && (cnt_q >= len);

  assign emit      = cmd_i.emit_mark | cmd_i.emit_head;
  assign sh        = cmd_i.emit_mark ? len : CntW'(1);
  assign slot_free = !out_valid_q || out_ready_i;

  // Append a byte, or drop the emitted bytes from the front
  always_comb begin
    logic [CntW:0] src;
    src   = '0;
    buf_d = buf_q;
    cnt_d = cnt_q;
    last_d = last_q;
    if (cmd_i.load) begin
      for (int i = 0; i < PatMax; i++) begin
        if (cnt_q == CntW'(i)) begin
          buf_d[i] = text_byte_i;
        end
      end
      cnt_d  = cnt_q + CntW'(1);
      last_d = text_last_i;
    end else if (emit) begin
      for (int i = 0; i < PatMax; i++) begin
        src = (CntW+1)'(i) + {1'b0, sh};
        if (src < (CntW+1)'(PatMax)) begin
          buf_d[i] = buf_q[src[IdxW-1:0]];
        end
      end
      cnt_d = cnt_q - sh;
    end
  end

  // Output register: load on emit, clear once taken
  always_comb begin
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_mark_d  = out_mark_q;
    out_last_d  = out_last_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_byte_d  = cmd_i.emit_mark ? marker_i : buf_q[0];
      out_mark_d  = cmd_i.emit_mark;
      out_last_d  = last_q && (cnt_q == sh);
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q      <= buf_d;
    out_byte_q <= out_byte_d;
    out_mark_q <= out_mark_d;
    out_last_q <= out_last_d;
  end

  assign sts_o.empty     = (cnt_q == '0);
  assign sts_o.full      = full;
  assign sts_o.match     = match;
  assign sts_o.last      = last_q;
  assign sts_o.slot_free = slot_free;

  assign out_valid_o     = out_valid_q;
  assign out_byte_o      = out_byte_q;
  assign out_is_marker_o = out_mark_q;
  assign out_last_o      = out_last_q;

  // Checks
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(PatMax))
    else $error("pending count beyond buffer depth");

  a_emit_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> slot_free)
    else $error("emit while output register is occupied");

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.load && emit) && !(cmd_i.emit_mark && cmd_i.emit_head))
    else $error("conflicting datapath commands");

  a_mark_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_mark |-> full)
    else $error("marker emitted without a full match");

  a_last_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && out_last_d) |=> (cnt_q == '0))
    else $error("final beat left bytes pending");

endmodule

/* rtl/core/prm_ctrl.sv */
`timescale 1ns / 1ps

module prm_ctrl import prm_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Take a byte, then resolve the pending buffer one beat at a time
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StScan;
        end
      end
      StScan: begin
        if (sts_i.empty) begin
          state_d = StIdle;
        end else if (sts_i.full) begin
          cmd_o.emit_mark = sts_i.slot_free;
        end else if (!sts_i.match || sts_i.last) begin
          // mismatch, or final flush: release the oldest byte
          cmd_o.emit_head = sts_i.slot_free;
        end else begin
          // partial match, hold for more text
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

endmodule

/* rtl/core/pattern_replace_with_marker.sv */
`timescale 1ns / 1ps

// Streaming find-and-replace. Text bytes enter on the s_axis channel, one per
// beat, with tlast on the final byte of a text. Each leftmost, non-overlapping
// occurrence of the configured pattern (1 to PatMax bytes) leaves on m_axis as
// one marker byte with tuser high; every other byte leaves unchanged with
// tuser low. Bytes that may still begin a match are held internally, so an
// input beat yields zero or more output beats. The final input byte flushes
// everything held, and tlast marks the last output beat of that text.
// Registers on the APB port (64-bit, at 8*i): pattern bytes 0-7, pattern
// bytes 8-15, pattern length, marker byte. Write them while the block is idle;
// held bytes are checked against the new pattern when the next byte arrives.
// Timing: one byte is worked at a time. A byte is accepted in the idle state;
// the scan state then issues the output beats one at a time, and returns to
// idle once nothing is held or only a partial match is left. A marker beat
// drops the whole matched pattern from the buffer, any other beat one byte.
// A stalled m_axis_tready holds the output register and pauses the scan.
// Reset clears the held bytes, sets length 1 and marker '*'.
module pattern_replace_with_marker import prm_pkg::*; #(
  parameter int unsigned PatMax = PatMaxDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // APB configuration
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [CfgW-1:0]  pwdata,
  output logic [CfgW-1:0]  prdata,
  output logic             pready,
  // Text in
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [7:0]       s_axis_tdata,   // [7:0] text_byte
  input  logic             s_axis_tlast,   // text_last
  // Text out
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [7:0] out_byte
  output logic             m_axis_tuser,   // [0] out_is_marker
  output logic             m_axis_tlast    // out_last
);

  logic [PatW-1:0]  pattern;
  logic [LenW-1:0]  pattern_length;
  logic [ByteW-1:0] marker;
  dp_cmd_t          cmd;
  dp_sts_t          sts;

  prm_regs u_regs (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .pattern_o        (pattern),
    .pattern_length_o (pattern_length),
    .marker_o         (marker)
  );

  prm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  prm_datapath #(
    .PatMax (PatMax)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .text_byte_i      (s_axis_tdata),
    .text_last_i      (s_axis_tlast),
    .pattern_i        (pattern),
    .pattern_length_i (pattern_length),
    .marker_i         (marker),
    .out_ready_i      (m_axis_tready),
    .out_valid_o      (m_axis_tvalid),
    .out_byte_o       (m_axis_tdata),
    .out_is_marker_o  (m_axis_tuser),
    .out_last_o       (m_axis_tlast)
  );

endmodule

/* tb/sv/pattern_replace_with_marker_tb.sv */
`timescale 1ns / 1ps

module pattern_replace_with_marker_tb import prm_pkg::*; ();

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 24;
  localparam int unsigned MaxReports  = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       mark;
    logic       last;
  } text_beat_t;

  typedef enum logic [1:0] {
    RxOpen,
    RxRandom,
    RxPeriodic,
    RxChoked
  } rx_mode_e;

  logic             clk_i  = 1'b0;
  logic             rst_ni = 1'b0;
  logic             psel    = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite  = 1'b0;
  logic [AddrW-1:0] paddr   = '0;
  logic [CfgW-1:0]  pwdata  = '0;
  logic [CfgW-1:0]  prdata;
  logic             pready;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [7:0]       s_axis_tdata  = '0;  // [7:0] text_byte
  logic             s_axis_tlast  = 1'b0; // text_last
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b1;
  logic [7:0]       m_axis_tdata;         // [7:0] out_byte
  logic             m_axis_tuser;         // [0] out_is_marker
  logic             m_axis_tlast;         // out_last

  // Shadow of the register file and of the held bytes
  logic [63:0]  cfg_pat_lo;
  logic [63:0]  cfg_pat_hi;
  logic [4:0]   cfg_len;
  logic [7:0]   cfg_marker;
  logic [7:0]   held [0:14];
  int unsigned  held_cnt;

  text_beat_t   rewritten_q [$];
  int unsigned  err_cnt  = 0;
  int unsigned  n_sent   = 0;
  int unsigned  cycle_cnt = 0;
  int unsigned  tx_burst_left = 0;
  int unsigned  rx_left = 0;
  int unsigned  rx_tick = 0;
  rx_mode_e     rx_mode = RxOpen;

  pattern_replace_with_marker u_dut (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tlast,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .m_axis_tlast
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("pattern_replace_with_marker_tb: done, errors");
      $finish;
    end
  end

  function automatic void flag_error(string msg);
    err_cnt++;
    if (err_cnt <= MaxReports) $display("%s", msg);
  endfunction

  // Length in force: zero acts as one, anything past the maximum is clipped
  function automatic int unsigned active_len();
    if (cfg_len == 5'd0) return 1;
    if (cfg_len > PatMaxDef) return PatMaxDef;
    return cfg_len;
  endfunction

  function automatic logic [7:0] pat_byte(int unsigned k);
    logic [127:0] pat;
    pat = {cfg_pat_hi, cfg_pat_lo};
    return pat[8*(k%16) +: 8];
  endfunction

  // Work out the output beats that one text byte releases
  function automatic void predict_rewrite(logic [7:0] txt, logic txt_last);
    logic [7:0]  hold [0:15];
    int unsigned cnt;
    int unsigned len;
    int unsigned cmp;
    int unsigned step;
    bit          ok;
    text_beat_t  res [$];
    cnt = held_cnt;
    len = active_len();
    for (int i = 0; i < cnt; i++) hold[i] = held[i];
    hold[cnt] = txt;
    cnt++;
    while (cnt > 0) begin
      cmp = (cnt < len) ? cnt : len;
      ok  = 1'b1;
      for (int i = 0; i < cmp; i++) begin
        if (hold[i] != pat_byte(i)) ok = 1'b0;
      end
      if (ok && cnt < len) break;
      if (ok) begin
        res.push_back('{data: cfg_marker, mark: 1'b1, last: 1'b0});
        step = len;
      end else begin
        res.push_back('{data: hold[0], mark: 1'b0, last: 1'b0});
        step = 1;
      end
      for (int i = 0; i + step < cnt; i++) hold[i] = hold[i+step];
      cnt -= step;
    end
    // Flush whatever is still held at the end of a text
    if (txt_last) begin
      for (int i = 0; i < cnt; i++) res.push_back('{data: hold[i], mark: 1'b0, last: 1'b0});
      cnt = 0;
      res[res.size()-1].last = 1'b1;
    end
    for (int i = 0; i < cnt; i++) held[i] = hold[i];
    held_cnt = cnt;
    foreach (res[i]) rewritten_q.push_back(res[i]);
  endfunction

  // Read one register and compare with the shadow copy
  task automatic cfg_read_check(reg_idx_e idx);
    logic [63:0] want;
    case (idx)
      RegPatLo:  want = cfg_pat_lo;
      RegPatHi:  want = cfg_pat_hi;
      RegPatLen: want = 64'(cfg_len);
      default:   want = 64'(cfg_marker);
    endcase
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 3'b000};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== want) begin
      flag_error($sformatf("register %s readback: exp %h got %h", idx.name(), want, prdata));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write one register, track it, and read it back
  task automatic cfg_write(reg_idx_e idx, logic [63:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      RegPatLo:  cfg_pat_lo = val;
      RegPatHi:  cfg_pat_hi = val;
      RegPatLen: cfg_len    = val[4:0];
      default:   cfg_marker = val[7:0];
    endcase
    cfg_read_check(idx);
  endtask

  // Send one text beat; bursts of random length with gaps between them
  task automatic send_text_byte(logic [7:0] txt, logic txt_last);
    if (tx_burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      tx_burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 8);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= txt;
    s_axis_tlast  <= txt_last;
    do @(posedge clk_i); while (!s_axis_tready);
    tx_burst_left--;
    n_sent++;
    predict_rewrite(txt, txt_last);
  endtask

  // Stop sending and let every expected beat come out
  task automatic drain_output();
    s_axis_tvalid <= 1'b0;
    while (rewritten_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic rand_last();
    return ($urandom_range(0, 19) == 0);
  endfunction

  // Receiver stalls on its own pattern, changing to a random mode after each run of random length
  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(16, 96);
    end
    rx_left--;
    rx_tick++;
    case (rx_mode)
      RxOpen:     m_axis_tready <= 1'b1;
      RxRandom:   m_axis_tready <= ($urandom_range(0, 3) != 0);
      RxPeriodic: m_axis_tready <= ((rx_tick % 7) < 3);
      default:    m_axis_tready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  // Compare each output beat with the oldest expected one
  always @(posedge clk_i) begin
    text_beat_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (rewritten_q.size() == 0) begin
        flag_error($sformatf("unexpected beat: data %h mark %b last %b",
                             m_axis_tdata, m_axis_tuser, m_axis_tlast));
      end else begin
        want = rewritten_q.pop_front();
        if (m_axis_tdata !== want.data || m_axis_tuser !== want.mark ||
            m_axis_tlast !== want.last) begin
          flag_error($sformatf("beat mismatch: exp data %h mark %b last %b, got %h %b %b",
                               want.data, want.mark, want.last,
                               m_axis_tdata, m_axis_tuser, m_axis_tlast));
        end
      end
    end
  end

  // Reset values; the marker byte and a zero pattern byte inside the text
  task automatic test_reset_values();
    cfg_read_check(RegPatLo);
    cfg_read_check(RegPatHi);
    cfg_read_check(RegPatLen);
    cfg_read_check(RegMarker);
    send_text_byte(8'h00, 1'b0);
    send_text_byte(MarkerReset, 1'b0);
    send_text_byte(8'hFF, 1'b1);
    drain_output();
  endtask

  // Length zero acts as one; marker 0x00 also appears as a plain text byte
  task automatic test_zero_length();
    cfg_write(RegPatLo, 64'h5AA5_0000_FFFF_FF41);
    cfg_write(RegPatLen, 64'hFFFF_FFFF_FFFF_FFE0);
    cfg_write(RegMarker, 64'hFFFF_FFFF_FFFF_FF00);
    send_text_byte(8'h41, 1'b0);
    send_text_byte(8'h00, 1'b1);
    drain_output();
  endtask

  // Oversized length clips to the full 16-byte pattern across both words
  task automatic test_full_pattern();
    cfg_write(RegPatLo, 64'hFF00_7F80_0102_0408);
    cfg_write(RegPatHi, 64'h1020_4080_AA55_C33C);
    cfg_write(RegPatLen, 64'hFFFF_FFFF_FFFF_FFFF);
    cfg_write(RegMarker, 64'h0000_0000_0000_00FF);
    for (int unsigned k = 0; k < 16; k++) send_text_byte(pat_byte(k), k == 15);
    drain_output();
  endtask

  // Failed partial match releases the oldest byte and rechecks the rest
  task automatic test_partial_fallback();
    cfg_write(RegPatLo, 64'h0000_0000_0062_6161);
    cfg_write(RegPatLen, 64'd3);
    cfg_write(RegMarker, 64'(MarkerReset));
    send_text_byte(8'h61, 1'b0);
    send_text_byte(8'h61, 1'b0);
    send_text_byte(8'h61, 1'b0);
    send_text_byte(8'h62, 1'b0);
    send_text_byte(8'h61, 1'b0);
    send_text_byte(8'h61, 1'b1);
    drain_output();
  endtask

  // Shorten the pattern while bytes are held; they match on the next byte
  task automatic test_config_mid_text();
    cfg_write(RegPatLo, 64'h0000_0000_0063_6261);
    cfg_write(RegPatLen, 64'd3);
    send_text_byte(8'h61, 1'b0);
    send_text_byte(8'h62, 1'b0);
    drain_output();
    cfg_write(RegPatLen, 64'd2);
    send_text_byte(8'h7A, 1'b1);
    drain_output();
  endtask

  // Random texts built mostly from pattern pieces, under changing settings
  task automatic test_random_texts(int unsigned n_items);
    int unsigned goal;
    int unsigned run_end;
    int unsigned plen;
    int unsigned cut;
    logic [63:0] word [2];
    goal = n_sent + n_items;
    while (n_sent < goal) begin
      drain_output();
      // New settings: small alphabet patterns give self-overlapping prefixes
      for (int w = 0; w < 2; w++) begin
        for (int b = 0; b < 8; b++) begin
          word[w][8*b +: 8] = ($urandom_range(0, 1) == 0) ? 8'(32'h61 + $urandom_range(0, 1))
                                                           : 8'($urandom_range(0, 255));
        end
      end
      if ($urandom_range(0, 9) < 7) cfg_write(RegPatLo, word[0]);
      if ($urandom_range(0, 9) < 5) cfg_write(RegPatHi, word[1]);
      case ($urandom_range(0, 9))
        0:       cfg_write(RegPatLen, ($urandom_range(0, 1) == 0) ? 64'd0
                                                                  : 64'($urandom_range(17, 31)));
        1:       cfg_write(RegPatLen, 64'd16);
        default: cfg_write(RegPatLen, 64'($urandom_range(1, 5)));
      endcase
      if ($urandom_range(0, 1) == 0) cfg_write(RegMarker, {$urandom, $urandom});
      run_end = n_sent + $urandom_range(25, 60);
      while (n_sent < run_end) begin
        plen = active_len();
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            for (int unsigned k = 0; k < plen; k++) begin
              send_text_byte(pat_byte(k), (k == plen - 1) ? rand_last() : 1'b0);
            end
          end
          4, 5: begin
            cut = $urandom_range(0, plen - 1);
            for (int unsigned k = 0; k < cut; k++) send_text_byte(pat_byte(k), 1'b0);
            send_text_byte(8'($urandom_range(0, 255)), rand_last());
          end
          6, 7: send_text_byte(pat_byte($urandom_range(0, plen - 1)), rand_last());
          default: send_text_byte(8'($urandom_range(0, 255)), rand_last());
        endcase
      end
      // Mostly close the text; otherwise leave bytes held across the next setting
      if ($urandom_range(0, 3) != 0) send_text_byte(8'($urandom_range(0, 255)), 1'b1);
    end
    drain_output();
  endtask

  initial begin
    cfg_pat_lo = '0;
    cfg_pat_hi = '0;
    cfg_len    = LenReset;
    cfg_marker = MarkerReset;
    held_cnt   = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_values();
    test_zero_length();
    test_full_pattern();
    test_partial_fallback();
    test_config_mid_text();
    test_random_texts(430);
    if (err_cnt == 0 && rewritten_q.size() == 0) begin
      $display("pattern_replace_with_marker_tb: done, clean");
    end else begin
      $display("pattern_replace_with_marker_tb: done, errors");
    end
    $finish;
  end

endmodule
